// ===== hdl/owm_pkg.sv =====
// Package for the 1-Wire bus master slot timer.
// Holds opcodes, phase codes, register indexes, defaults and the result record.
// Used by owm_slot and onewire_bus_master_slots.
package owm_pkg;

	localparam int TIME_WIDTH_DEFAULT = 10;
	localparam int OP_W               = 3;
	localparam int DATA_W             = 8;
	localparam int PHASE_W            = 3;
	localparam int BITPOS_W           = 3;
	localparam int NUM_REGS           = 7;
	localparam int CFG_INDEX_W        = 3;

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_RESET = 3'd1;
	localparam logic [OP_W-1:0] OP_WBIT  = 3'd2;
	localparam logic [OP_W-1:0] OP_RBIT  = 3'd3;
	localparam logic [OP_W-1:0] OP_WBYTE = 3'd4;
	localparam logic [OP_W-1:0] OP_RBYTE = 3'd5;

	localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RST_REL   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SLOT_LOW  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SLOT_HIGH = 3'd4;
	localparam logic [PHASE_W-1:0] PH_RECOVER   = 3'd5;

	localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_SMP  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_RELEASE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG          = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_READ_SMP      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY      = 3'd6;

	localparam int RESET_LOW_DEFAULT     = 480;
	localparam int PRESENCE_SMP_DEFAULT  = 70;
	localparam int RESET_RELEASE_DEFAULT = 480;
	localparam int SHORT_DEFAULT         = 1;
	localparam int LONG_DEFAULT          = 60;
	localparam int READ_SMP_DEFAULT      = 15;
	localparam int RECOVERY_DEFAULT      = 1;

	typedef struct packed {
		logic              drive_low;
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] read_data;
		logic              present;
		logic              rejected;
	} result_t;

endpackage

// ===== hdl/onewire_bus_master_slots.sv =====
// Top level of the 1-Wire bus master slot timer.
// Input register, timing registers, slot engine and result register.
// Depends on owm_pkg and owm_slot.
//
// Usage: every input item is a command (reset, write bit, read bit, write
// byte, read byte) or a tick of one microsecond carrying the sampled line
// level. Every item produces exactly one result item showing the line drive,
// busy and done flags, and the read data or presence flag at the end of an
// operation. A command arriving while busy is answered with rejected set.
// Timing registers are to be written through the cfg channel only while idle;
// the block does not enforce this. The cfg channel is always ready and
// indexes beyond six are ignored. An item is captured in the input register,
// and the slot engine then updates its state and loads the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single pass through the slot engine. When the receiver stalls, the
// result register holds and the input register fills; in_ready falls only
// when both are occupied. Reset empties both registers, puts the engine in
// idle and loads the default timing values.
module onewire_bus_master_slots #(
	parameter int TIME_WIDTH = owm_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [owm_pkg::OP_W-1:0]          opcode,
	input  logic [owm_pkg::DATA_W-1:0]        data,
	input  logic                              line_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              drive_low,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [owm_pkg::DATA_W-1:0]        read_data,
	output logic                              present,
	output logic                              rejected,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [owm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [TIME_WIDTH-1:0]             cfg_data
);
	import owm_pkg::*;

	logic                                 valid_s1;
	logic [OP_W-1:0]                      opcode_s1;
	logic [DATA_W-1:0]                    data_s1;
	logic                                 level_s1;
	logic                                 valid_s2;
	result_t                              res_s2;
	result_t                              res;
	logic                                 step;
	logic [NUM_REGS-1:0][TIME_WIDTH-1:0]  cfg_q;

	assign step      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			data_s1   <= data;
			level_s1  <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_RESET_LOW]     <= TIME_WIDTH'(RESET_LOW_DEFAULT);
			cfg_q[REG_PRESENCE_SMP]  <= TIME_WIDTH'(PRESENCE_SMP_DEFAULT);
			cfg_q[REG_RESET_RELEASE] <= TIME_WIDTH'(RESET_RELEASE_DEFAULT);
			cfg_q[REG_SHORT]         <= TIME_WIDTH'(SHORT_DEFAULT);
			cfg_q[REG_LONG]          <= TIME_WIDTH'(LONG_DEFAULT);
			cfg_q[REG_READ_SMP]      <= TIME_WIDTH'(READ_SMP_DEFAULT);
			cfg_q[REG_RECOVERY]      <= TIME_WIDTH'(RECOVERY_DEFAULT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESET_LOW:     cfg_q[REG_RESET_LOW]     <= cfg_data;
				REG_PRESENCE_SMP:  cfg_q[REG_PRESENCE_SMP]  <= cfg_data;
				REG_RESET_RELEASE: cfg_q[REG_RESET_RELEASE] <= cfg_data;
				REG_SHORT:         cfg_q[REG_SHORT]         <= cfg_data;
				REG_LONG:          cfg_q[REG_LONG]          <= cfg_data;
				REG_READ_SMP:      cfg_q[REG_READ_SMP]      <= cfg_data;
				REG_RECOVERY:      cfg_q[REG_RECOVERY]      <= cfg_data;
				default: ;
			endcase
		end
	end

	owm_slot #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_slot (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.opcode     (opcode_s1),
		.data       (data_s1),
		.line_level (level_s1),
		.cfg_regs   (cfg_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign drive_low = res_s2.drive_low;
	assign busy_res  = res_s2.busy;
	assign done_res  = res_s2.done;
	assign read_data = res_s2.read_data;
	assign present   = res_s2.present;
	assign rejected  = res_s2.rejected;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("result changed while stalled");
	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2) else $error("stepped item did not reach the output");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full");

endmodule

// ===== hdl/owm_slot.sv =====
// Slot engine of the 1-Wire bus master: phase, tick counter and shift register.
// Computes the result of one item from the current state in a single pass.
// Depends on owm_pkg.
module owm_slot #(
	parameter int TIME_WIDTH = owm_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            step,
	input  logic [owm_pkg::OP_W-1:0]                        opcode,
	input  logic [owm_pkg::DATA_W-1:0]                      data,
	input  logic                                            line_level,
	input  logic [owm_pkg::NUM_REGS-1:0][TIME_WIDTH-1:0]    cfg_regs,
	output owm_pkg::result_t                                res
);
	import owm_pkg::*;

	logic [PHASE_W-1:0]                  phase_q, phase_d;
	logic [TIME_WIDTH-1:0]               tick_q, tick_d, cnt;
	logic [BITPOS_W-1:0]                 bitpos_q, bitpos_d;
	logic [DATA_W-1:0]                   shift_q, shift_d;
	logic [OP_W-1:0]                     opkind_q, opkind_d;
	logic                                pres_q, pres_d;
	logic [NUM_REGS-1:0][TIME_WIDTH-1:0] eff;
	logic                                is_write, is_read, wzero, single;
	logic [TIME_WIDTH-1:0]               pres_sp, read_sp, low_dur, high_dur;

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			eff[i] = (cfg_regs[i] == '0) ? TIME_WIDTH'(1) : cfg_regs[i];
		end
	end

	assign cnt      = tick_q + TIME_WIDTH'(1);
	assign is_write = (opkind_q == OP_WBIT) || (opkind_q == OP_WBYTE);
	assign is_read  = (opkind_q == OP_RBIT) || (opkind_q == OP_RBYTE);
	assign single   = (opkind_q == OP_WBIT) || (opkind_q == OP_RBIT);
	assign wzero    = is_write && !shift_q[0];
	assign low_dur  = wzero ? eff[REG_LONG] : eff[REG_SHORT];
	assign high_dur = wzero ? eff[REG_SHORT] : eff[REG_LONG];
	assign pres_sp  = (eff[REG_PRESENCE_SMP] < eff[REG_RESET_RELEASE]) ?
	                  eff[REG_PRESENCE_SMP] : eff[REG_RESET_RELEASE];
	assign read_sp  = (eff[REG_READ_SMP] < high_dur) ? eff[REG_READ_SMP] : high_dur;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bitpos_d = bitpos_q;
		shift_d  = shift_q;
		opkind_d = opkind_q;
		pres_d   = pres_q;
		res      = '0;
		case (opcode)
			OP_RESET, OP_WBIT, OP_RBIT, OP_WBYTE, OP_RBYTE: begin
				if (phase_q != PH_IDLE) begin
					res.rejected = 1'b1;
				end else begin
					opkind_d = opcode;
					tick_d   = '0;
					bitpos_d = '0;
					pres_d   = 1'b0;
					if (opcode == OP_RESET) begin
						phase_d = PH_RST_LOW;
						shift_d = '0;
					end else begin
						phase_d = PH_SLOT_LOW;
						if (opcode == OP_WBIT) shift_d = {{(DATA_W-1){1'b0}}, data[0]};
						else if (opcode == OP_WBYTE) shift_d = data;
						else shift_d = '0;
					end
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					tick_d = cnt;
					unique case (phase_q)
						PH_RST_LOW: begin
							if (cnt >= eff[REG_RESET_LOW]) begin
								phase_d = PH_RST_REL;
								tick_d  = '0;
							end
						end
						PH_RST_REL: begin
							if (cnt == pres_sp) pres_d = !line_level;
							if (cnt >= eff[REG_RESET_RELEASE]) begin
								phase_d     = PH_IDLE;
								tick_d      = '0;
								res.done    = 1'b1;
								res.present = (cnt == pres_sp) ? !line_level : pres_q;
							end
						end
						PH_SLOT_LOW: begin
							if (cnt >= low_dur) begin
								phase_d = PH_SLOT_HIGH;
								tick_d  = '0;
							end
						end
						PH_SLOT_HIGH: begin
							if (is_read && (cnt == read_sp)) begin
								shift_d = {line_level, shift_q[DATA_W-1:1]};
							end
							if (cnt >= high_dur) begin
								phase_d = PH_RECOVER;
								tick_d  = '0;
							end
						end
						PH_RECOVER: begin
							if (cnt >= eff[REG_RECOVERY]) begin
								if (is_write) shift_d = shift_q >> 1;
								bitpos_d = bitpos_q + BITPOS_W'(1);
								tick_d   = '0;
								if (single || (bitpos_q == '1)) begin
									phase_d  = PH_IDLE;
									res.done = 1'b1;
									bitpos_d = '0;
									if (opkind_q == OP_RBIT) begin
										res.read_data = {{(DATA_W-1){1'b0}}, shift_q[DATA_W-1]};
									end else if (opkind_q == OP_RBYTE) begin
										res.read_data = shift_q;
									end
								end else begin
									phase_d = PH_SLOT_LOW;
								end
							end
						end
						default: begin
							phase_d = PH_IDLE;
							tick_d  = '0;
						end
					endcase
				end
			end
			default: ;
		endcase
		res.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW);
		res.busy      = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bitpos_q <= '0;
			shift_q  <= '0;
			opkind_q <= OP_TICK;
			pres_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bitpos_q <= bitpos_d;
			shift_q  <= shift_d;
			opkind_q <= opkind_d;
			pres_q   <= pres_d;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done) |-> !res.busy) else $error("done while still busy");
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.rejected) |-> (res.busy && !res.done))
		else $error("reject while idle or done");
	a_present_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.present) |-> (res.done && opkind_q == OP_RESET))
		else $error("presence outside reset end");
	a_rdata_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.read_data != '0) |-> (res.done && is_read))
		else $error("read data outside read end");
	a_bitpos_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(bitpos_q != '0) |-> (opkind_q == OP_WBYTE || opkind_q == OP_RBYTE))
		else $error("bit position moved on a non-byte operation");

endmodule
